// ----- rtl/spi_ee_pkg.sv -----
package spi_ee_pkg;

    // Store depth used when the top level is not overridden
    localparam int STORE_DEPTH_DEF = 128;

    // Command codes
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;

    // Byte sent once the frame has nothing useful left to return
    localparam logic [7:0] SENTINEL  = 8'h85;

    // What the returned byte is
    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_READ     = 2'd1,
        PH_WRITE    = 2'd2,
        PH_SENTINEL = 2'd3
    } phase_t;

endpackage

// ----- rtl/spi_eeprom_slave.sv -----
// Channel   | tdata (low bit up) | tuser (low bit up)      | meaning
// s_axis    | mosi_byte[7:0]     | mode (1 = CS released)  | one SPI transfer or frame end
// m_axis    | miso_byte[7:0]     | frame_phase[1:0]        | byte returned for that transfer
//
// One item a cycle while the output is not stalled: each result is in the output register
// in the cycle after acceptance, and an item makes at most one store access (a read or a write).
// A chip-select release item gives no result and only returns the frame to its header.
// Reset clears the frame state and all store valid bits at once; no clearing pass is
// needed, an entry never written reads as its own index.
// s_axis_tready falls only while a result waits and m_axis_tready is low.
module spi_eeprom_slave #(
    parameter int STORE_DEPTH = spi_ee_pkg::STORE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] mosi_byte
    input  logic                s_axis_tuser,   // [0] mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] miso_byte
    output spi_ee_pkg::phase_t  m_axis_tuser    // [1:0] frame_phase
);
    import spi_ee_pkg::*;

    localparam int         AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

    typedef enum logic [1:0] {
        IDX_COMMAND,
        IDX_ADDRESS,
        IDX_DATA,
        IDX_SENTINEL
    } idx_t;

    idx_t              idx_reg, idx_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [7:0]        ptr_reg, ptr_next;
    logic              out_valid_reg;
    logic [7:0]        byte_reg, byte_next;
    phase_t            phase_reg, phase_next;
    logic              from_mem_reg;
    logic [7:0]        rd_data_reg;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]        mem [STORE_DEPTH];

    logic              accept;
    logic              xfer;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     addr;
    logic              ptr_in_range;
    logic              ptr_last;
    logic              cmd_ok;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign xfer          = accept && !s_axis_tuser;
    assign addr          = ptr_reg[AW-1:0];
    assign ptr_in_range  = {1'b0, ptr_reg} < DEPTH9;
    assign ptr_last      = ({1'b0, ptr_reg} + 9'd1) >= DEPTH9;
    assign cmd_ok        = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE);

    // Frame sequencing and the byte to return
    always_comb
    begin
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        ptr_next   = ptr_reg;
        byte_next  = 8'h00;
        phase_next = PH_HEADER;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        if (s_axis_tuser)
        begin
            idx_next = IDX_COMMAND;
        end
        else
        begin
            unique case (idx_reg)
                IDX_COMMAND:
                begin
                    cmd_next = s_axis_tdata;
                    idx_next = IDX_ADDRESS;
                end
                IDX_ADDRESS:
                begin
                    ptr_next = s_axis_tdata;
                    if (({1'b0, s_axis_tdata} < DEPTH9) && cmd_ok)
                        idx_next = IDX_DATA;
                    else
                        idx_next = IDX_SENTINEL;
                end
                IDX_DATA:
                begin
                    if (!ptr_in_range || !cmd_ok)
                    begin
                        idx_next   = IDX_SENTINEL;
                        byte_next  = SENTINEL;
                        phase_next = PH_SENTINEL;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_READ)
                        begin
                            rd_en      = 1'b1;
                            phase_next = PH_READ;
                            // an entry never written reads as its index
                            byte_next  = ptr_reg;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            phase_next = PH_WRITE;
                        end
                        if (ptr_last)
                            idx_next = IDX_SENTINEL;
                        else
                            ptr_next = ptr_reg + 8'd1;
                    end
                end
                IDX_SENTINEL:
                begin
                    byte_next  = SENTINEL;
                    phase_next = PH_SENTINEL;
                end
                default:
                begin
                    idx_next   = IDX_SENTINEL;
                    byte_next  = SENTINEL;
                    phase_next = PH_SENTINEL;
                end
            endcase
        end
    end

    // Hold frame state, valid bits and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_COMMAND;
            cmd_reg       <= 8'h00;
            ptr_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
            byte_reg      <= 8'h00;
            phase_reg     <= PH_HEADER;
            from_mem_reg  <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg       <= idx_next;
                cmd_reg       <= cmd_next;
                ptr_reg       <= ptr_next;
                out_valid_reg <= !s_axis_tuser;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (xfer)
            begin
                byte_reg     <= byte_next;
                phase_reg    <= phase_next;
                from_mem_reg <= rd_en && valid_reg[addr];
                if (wr_en)
                    valid_reg[addr] <= 1'b1;
            end
        end
    end

    // Store: at most one access per transfer, read data registered
    always_ff @(posedge clk)
    begin
        if (xfer && wr_en)
            mem[addr] <= s_axis_tdata;
        if (xfer && rd_en)
            rd_data_reg <= mem[addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = from_mem_reg ? rd_data_reg : byte_reg;
    assign m_axis_tuser  = phase_reg;

endmodule

// ----- rtl/spi_ee_chk.sv -----
module spi_ee_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [7:0]          m_axis_tdata,
    input  spi_ee_pkg::phase_t  m_axis_tuser
);
    import spi_ee_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Header and write data return zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == PH_HEADER || m_axis_tuser == PH_WRITE)
            |-> m_axis_tdata == 8'h00)
        else $error("header or write item returned non-zero byte");

    // Sentinel phase carries the sentinel byte
    a_sent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == PH_SENTINEL |-> m_axis_tdata == SENTINEL)
        else $error("sentinel phase without sentinel byte");

    // Input side only stalls while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with output free");

    // A chip-select release item produces no result
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && (!m_axis_tvalid || m_axis_tready)
            |=> !m_axis_tvalid)
        else $error("result produced for chip-select release");

endmodule

bind spi_eeprom_slave spi_ee_chk u_spi_ee_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
